### rtl/scc_pkg.sv
// Shared constants, types and helpers of the stopwatch / countdown controller.
`timescale 1ns / 1ps

package scc_pkg;

    // Counter limits and timing
    localparam int MAX_COUNT        = 9999;
    localparam int LINE_DEPTH       = 16;
    localparam int TICKS_PER_SECOND = 100;
    localparam int COUNTER_CEIL     = 16383;

    // Field widths
    localparam int COUNT_W = 14;
    localparam int SEC_W   = 7;
    localparam int CHAR_W  = 8;
    localparam int EV_W    = 3;
    localparam int LEN_W   = $clog2(LINE_DEPTH);
    localparam int ACC_CAP = 100;
    localparam int ACC_W   = $clog2(ACC_CAP + 1);
    localparam int LOAD_W  = SEC_W + $clog2(TICKS_PER_SECOND + 1);

    // Characters of the command line
    localparam logic [CHAR_W-1:0] CH_CR   = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_LF   = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_ZERO = 8'h30;
    localparam logic [CHAR_W-1:0] CH_ONE  = 8'h31;
    localparam logic [CHAR_W-1:0] CH_NINE = 8'h39;
    localparam logic [CHAR_W-1:0] CH_M    = 8'h4D;
    localparam logic [CHAR_W-1:0] CH_P    = 8'h50;
    localparam logic [CHAR_W-1:0] CH_R    = 8'h52;
    localparam logic [CHAR_W-1:0] CH_T    = 8'h54;

    // Input item kinds
    typedef enum logic [1:0] {
        OP_TICK       = 2'd0,
        OP_START_STOP = 2'd1,
        OP_RESET      = 2'd2,
        OP_CHAR       = 2'd3
    } t_op;

    // Commands decoded from a finished line
    typedef enum logic [2:0] {
        CMD_NONE = 3'd0,
        CMD_M0   = 3'd1,
        CMD_M1   = 3'd2,
        CMD_TSET = 3'd3,
        CMD_TBAD = 3'd4,
        CMD_TP   = 3'd5,
        CMD_TR   = 3'd6
    } t_cmd;

    // Event codes reported with each result
    typedef enum logic [EV_W-1:0] {
        EV_NONE     = 3'd0,
        EV_DONE     = 3'd1,
        EV_SW_MODE  = 3'd2,
        EV_TMR_MODE = 3'd3,
        EV_STARTED  = 3'd4,
        EV_BAD_TIME = 3'd5,
        EV_PAUSED   = 3'd6,
        EV_RESUMED  = 3'd7
    } t_event;

    // Classified item passed from the front to the back
    typedef struct packed {
        t_op               op;
        t_cmd              cmd;
        logic [SEC_W-1:0]  secs;
        logic [CHAR_W-1:0] ch;
    } t_cmd_item;

    function automatic logic is_digit(input logic [CHAR_W-1:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

endpackage

### rtl/scc_if.sv
// Valid/ready channel interfaces for input items and result items.
`timescale 1ns / 1ps

interface scc_in_if;
    logic                      valid;
    logic                      ready;
    logic [1:0]                op;
    logic [scc_pkg::CHAR_W-1:0] rx_char;

    modport source (output valid, op, rx_char, input ready);
    modport sink   (input valid, op, rx_char, output ready);
endinterface

interface scc_out_if;
    logic                        valid;
    logic                        ready;
    logic [scc_pkg::COUNT_W-1:0] count_value;
    logic                        running;
    logic                        mode;
    logic [scc_pkg::EV_W-1:0]    event_code;
    logic [scc_pkg::SEC_W-1:0]   set_seconds;
    logic                        echo_valid;
    logic [scc_pkg::CHAR_W-1:0]  echo_char;

    modport source (output valid, count_value, running, mode, event_code, set_seconds,
                    echo_valid, echo_char, input ready);
    modport sink   (input valid, count_value, running, mode, event_code, set_seconds,
                    echo_valid, echo_char, output ready);
endinterface

### rtl/scc_front.sv
// Front end: accepts items, gathers the command line and decodes finished lines.
`timescale 1ns / 1ps

module scc_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    scc_in_if.sink              i_in,
    output logic                o_push_valid,
    output scc_pkg::t_cmd_item  o_push_item,
    input  logic                i_push_ready
);

    logic [scc_pkg::LEN_W-1:0]  r_len, n_len;
    logic [scc_pkg::CHAR_W-1:0] r_first, n_first;
    logic [scc_pkg::CHAR_W-1:0] r_second, n_second;
    logic [scc_pkg::ACC_W-1:0]  r_accum, n_accum;
    logic                       r_done, n_done;

    logic                       accept;
    logic [scc_pkg::CHAR_W-1:0] ch;
    logic                       ch_digit;
    logic [3:0]                 dval;
    logic [scc_pkg::ACC_W+3:0]  acc_next;
    logic                       line_full;
    logic                       line_end;
    logic                       two;
    scc_pkg::t_cmd              cmd;

    assign accept       = i_in.valid && i_push_ready;
    assign i_in.ready   = i_push_ready;
    assign o_push_valid = i_in.valid;

    assign ch        = i_in.rx_char;
    assign ch_digit  = scc_pkg::is_digit(ch);
    assign dval      = 4'(ch - scc_pkg::CH_ZERO);
    assign acc_next  = (scc_pkg::ACC_W+4)'(r_accum) * (scc_pkg::ACC_W+4)'(10)
                     + (scc_pkg::ACC_W+4)'(dval);
    assign line_full = (r_len == scc_pkg::LEN_W'(scc_pkg::LINE_DEPTH - 1));
    assign line_end  = (ch == scc_pkg::CH_CR) || (ch == scc_pkg::CH_LF);
    assign two       = (r_len == scc_pkg::LEN_W'(2));

    // Decode the gathered line into a command
    always_comb begin
        cmd = scc_pkg::CMD_NONE;
        if (r_len != '0 && !line_full && line_end) begin
            if (two && r_first == scc_pkg::CH_M && r_second == scc_pkg::CH_ZERO) begin
                cmd = scc_pkg::CMD_M0;
            end else if (two && r_first == scc_pkg::CH_M && r_second == scc_pkg::CH_ONE) begin
                cmd = scc_pkg::CMD_M1;
            end else if (r_first == scc_pkg::CH_T && r_len >= scc_pkg::LEN_W'(2)
                         && scc_pkg::is_digit(r_second)) begin
                if (r_accum >= scc_pkg::ACC_W'(1) && r_accum <= scc_pkg::ACC_W'(99))
                    cmd = scc_pkg::CMD_TSET;
                else
                    cmd = scc_pkg::CMD_TBAD;
            end else if (two && r_first == scc_pkg::CH_T && r_second == scc_pkg::CH_P) begin
                cmd = scc_pkg::CMD_TP;
            end else if (two && r_first == scc_pkg::CH_T && r_second == scc_pkg::CH_R) begin
                cmd = scc_pkg::CMD_TR;
            end
        end
    end

    assign o_push_item.op   = scc_pkg::t_op'(i_in.op);
    assign o_push_item.cmd  = (scc_pkg::t_op'(i_in.op) == scc_pkg::OP_CHAR)
                            ? cmd : scc_pkg::CMD_NONE;
    assign o_push_item.secs = scc_pkg::SEC_W'(r_accum);
    assign o_push_item.ch   = ch;

    // Line gathering and incremental digit parse
    always_comb begin
        n_len    = r_len;
        n_first  = r_first;
        n_second = r_second;
        n_accum  = r_accum;
        n_done   = r_done;
        if (accept && scc_pkg::t_op'(i_in.op) == scc_pkg::OP_CHAR) begin
            if (line_full || line_end) begin
                n_len = '0;
            end else begin
                n_len = r_len + scc_pkg::LEN_W'(1);
                if (r_len == '0) begin
                    n_first = ch;
                    n_accum = '0;
                    n_done  = 1'b0;
                end else if (r_len == scc_pkg::LEN_W'(1)) begin
                    n_second = ch;
                    if (ch_digit) n_accum = scc_pkg::ACC_W'(dval);
                    else          n_done  = 1'b1;
                end else if (!r_done) begin
                    if (ch_digit) begin
                        if (acc_next > (scc_pkg::ACC_W+4)'(scc_pkg::ACC_CAP))
                            n_accum = scc_pkg::ACC_W'(scc_pkg::ACC_CAP);
                        else
                            n_accum = scc_pkg::ACC_W'(acc_next);
                    end else begin
                        n_done = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len    <= '0;
            r_first  <= '0;
            r_second <= '0;
            r_accum  <= '0;
            r_done   <= 1'b0;
        end else begin
            r_len    <= n_len;
            r_first  <= n_first;
            r_second <= n_second;
            r_accum  <= n_accum;
            r_done   <= n_done;
        end
    end

endmodule

### rtl/scc_queue.sv
// Two-entry queue between the front end and the execution back end.
`timescale 1ns / 1ps

module scc_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push_valid,
    input  scc_pkg::t_cmd_item  i_push_item,
    output logic                o_push_ready,
    output logic                o_pop_valid,
    output scc_pkg::t_cmd_item  o_pop_item,
    input  logic                i_pop_ready
);

    scc_pkg::t_cmd_item r_mem [2];
    logic               r_wptr, n_wptr;
    logic               r_rptr, n_rptr;
    logic [1:0]         r_count, n_count;
    logic               push;
    logic               pop;

    assign o_push_ready = (r_count != 2'd2);
    assign o_pop_valid  = (r_count != 2'd0);
    assign o_pop_item   = r_mem[r_rptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    // Pointer and fill bookkeeping
    always_comb begin
        n_wptr  = push ? ~r_wptr : r_wptr;
        n_rptr  = pop  ? ~r_rptr : r_rptr;
        n_count = r_count + 2'(push) - 2'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wptr] <= i_push_item;
    end

endmodule

### rtl/scc_back.sv
// Back end: runs the counter, applies commands and holds the result register.
`timescale 1ns / 1ps

module scc_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_pop_valid,
    input  scc_pkg::t_cmd_item  i_pop_item,
    output logic                o_pop_ready,
    scc_out_if.source           o_out
);

    logic [scc_pkg::COUNT_W-1:0] r_count, n_count;
    logic                        r_run, n_run;
    logic                        r_mode, n_mode;
    logic                        r_valid;

    logic [scc_pkg::COUNT_W-1:0] r_o_count;
    logic                        r_o_run;
    logic                        r_o_mode;
    scc_pkg::t_event             r_o_event, n_event;
    logic [scc_pkg::SEC_W-1:0]   r_o_secs, n_secs;
    logic                        r_o_echo_v;
    logic [scc_pkg::CHAR_W-1:0]  r_o_echo;

    logic                        take;
    logic [scc_pkg::LOAD_W-1:0]  load;
    logic [scc_pkg::COUNT_W-1:0] load_sat;
    logic [scc_pkg::COUNT_W-1:0] dec;

    assign o_pop_ready = !r_valid || o_out.ready;
    assign take        = i_pop_valid && o_pop_ready;

    // Timer preset, saturated to the counter width
    assign load     = scc_pkg::LOAD_W'(i_pop_item.secs)
                    * scc_pkg::LOAD_W'(scc_pkg::TICKS_PER_SECOND);
    assign load_sat = (load > scc_pkg::LOAD_W'(scc_pkg::COUNTER_CEIL))
                    ? scc_pkg::COUNT_W'(scc_pkg::COUNTER_CEIL) : scc_pkg::COUNT_W'(load);
    assign dec      = (r_count != '0) ? r_count - scc_pkg::COUNT_W'(1) : r_count;

    // Execute one classified item
    always_comb begin
        n_count = r_count;
        n_run   = r_run;
        n_mode  = r_mode;
        n_event = scc_pkg::EV_NONE;
        n_secs  = '0;
        case (i_pop_item.op)
            scc_pkg::OP_TICK: begin
                if (r_run) begin
                    if (!r_mode) begin
                        if (r_count < scc_pkg::COUNT_W'(scc_pkg::MAX_COUNT))
                            n_count = r_count + scc_pkg::COUNT_W'(1);
                        else
                            n_run = 1'b0;
                    end else begin
                        n_count = dec;
                        if (dec == '0) begin
                            n_run   = 1'b0;
                            n_event = scc_pkg::EV_DONE;
                        end
                    end
                end
            end
            scc_pkg::OP_START_STOP: begin
                if (!r_mode) n_run = !r_run;
            end
            scc_pkg::OP_RESET: begin
                if (!r_mode && !r_run) n_count = '0;
            end
            default: begin
                unique case (i_pop_item.cmd)
                    scc_pkg::CMD_M0: begin
                        n_mode  = 1'b0;
                        n_run   = 1'b0;
                        n_count = '0;
                        n_event = scc_pkg::EV_SW_MODE;
                    end
                    scc_pkg::CMD_M1: begin
                        n_mode  = 1'b1;
                        n_run   = 1'b0;
                        n_count = '0;
                        n_event = scc_pkg::EV_TMR_MODE;
                    end
                    scc_pkg::CMD_TSET: begin
                        if (r_mode) begin
                            n_count = load_sat;
                            n_run   = 1'b1;
                            n_secs  = i_pop_item.secs;
                            n_event = scc_pkg::EV_STARTED;
                        end
                    end
                    scc_pkg::CMD_TBAD: begin
                        if (r_mode) n_event = scc_pkg::EV_BAD_TIME;
                    end
                    scc_pkg::CMD_TP: begin
                        if (r_mode) begin
                            n_run   = 1'b0;
                            n_event = scc_pkg::EV_PAUSED;
                        end
                    end
                    scc_pkg::CMD_TR: begin
                        if (r_mode && r_count != '0) begin
                            n_run   = 1'b1;
                            n_event = scc_pkg::EV_RESUMED;
                        end
                    end
                    default: ;
                endcase
            end
        endcase
    end

    // Architectural state and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_run   <= 1'b0;
            r_mode  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            if (take) begin
                r_count <= n_count;
                r_run   <= n_run;
                r_mode  <= n_mode;
            end
            if (o_pop_ready) r_valid <= i_pop_valid;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_o_count  <= n_count;
            r_o_run    <= n_run;
            r_o_mode   <= n_mode;
            r_o_event  <= n_event;
            r_o_secs   <= n_secs;
            r_o_echo_v <= (i_pop_item.op == scc_pkg::OP_CHAR);
            r_o_echo   <= (i_pop_item.op == scc_pkg::OP_CHAR) ? i_pop_item.ch : '0;
        end
    end

    assign o_out.valid       = r_valid;
    assign o_out.count_value = r_o_count;
    assign o_out.running     = r_o_run;
    assign o_out.mode        = r_o_mode;
    assign o_out.event_code  = r_o_event;
    assign o_out.set_seconds = r_o_secs;
    assign o_out.echo_valid  = r_o_echo_v;
    assign o_out.echo_char   = r_o_echo;

endmodule

### rtl/stopwatch_countdown_controller_unit.sv
// Path: a result is presented once its item has passed the queue and then the result
// register, and it is held until the downstream ready takes it.
// Throughput: one item per cycle while the queue is not full; the two-entry queue lets the
// front keep accepting items while the result register waits on the downstream ready.
// Reset: synchronous active-low i_rst_n clears the count, run flag, mode (stopwatch),
// the command line state and the queue; the block accepts items right after reset.
`timescale 1ns / 1ps

module stopwatch_countdown_controller_unit (
    input  logic      i_clk,
    input  logic      i_rst_n,
    scc_in_if.sink    i_in,
    scc_out_if.source o_out
);

    logic               push_valid;
    logic               push_ready;
    scc_pkg::t_cmd_item push_item;
    logic               pop_valid;
    logic               pop_ready;
    scc_pkg::t_cmd_item pop_item;

    scc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .o_push_valid (push_valid),
        .o_push_item  (push_item),
        .i_push_ready (push_ready)
    );

    scc_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .i_push_item  (push_item),
        .o_push_ready (push_ready),
        .o_pop_valid  (pop_valid),
        .o_pop_item   (pop_item),
        .i_pop_ready  (pop_ready)
    );

    scc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_valid (pop_valid),
        .i_pop_item  (pop_item),
        .o_pop_ready (pop_ready),
        .o_out       (o_out)
    );

    // A finished countdown leaves the timer stopped at zero
    a_done_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.event_code == scc_pkg::EV_DONE
        |-> !o_out.running && o_out.count_value == '0)
        else $error("timer done without stopped zero count");

    // Seconds are reported exactly with a start event
    a_secs_with_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |->
        ((o_out.set_seconds != '0) == (o_out.event_code == scc_pkg::EV_STARTED)))
        else $error("set_seconds does not match start event");

    // Mode commands clear and stop the count and set the mode
    a_mode_switch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && (o_out.event_code == scc_pkg::EV_SW_MODE ||
                        o_out.event_code == scc_pkg::EV_TMR_MODE)
        |-> o_out.count_value == '0 && !o_out.running &&
            (o_out.mode == (o_out.event_code == scc_pkg::EV_TMR_MODE)))
        else $error("mode switch left count or mode wrong");

    // Only character items carry command events
    a_cmd_from_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.echo_valid
        |-> (o_out.event_code == scc_pkg::EV_NONE || o_out.event_code == scc_pkg::EV_DONE))
        else $error("command event on a non-character item");

endmodule
